// ----- sv/circular_deque_top_defines.svh -----
// ---------------------------------------------------------------------------
// Circular deque assertion macros
// Shared assertion forms used by the circular deque top level.
// ---------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_TOP_DEFINES_SVH
`define CIRCULAR_DEQUE_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define CD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("circular deque check failed");
`define CD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("circular deque check failed");
`else
`define CD_ASSERT_SAME(label, ante, cons)
`define CD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- sv/cd_pkg.sv -----
// ---------------------------------------------------------------------------
// Circular deque package
// Types, constants and pointer helpers shared by the deque modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cd_pkg;

  localparam int DEPTH = 1024;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = PTR_W + 1;
  localparam int DATA_W = 32;

  localparam logic signed [DATA_W-1:0] NONE_VALUE = '1;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_QUERY      = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]               opcode;
    logic signed [DATA_W-1:0] push_value;
  } request_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic [1:0]               status;
    logic [CNT_W-1:0]         entry_count;
    logic                     is_empty;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
  } result_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic fetch;
    logic capture;
  } cd_cmd_t;

  function automatic logic [PTR_W-1:0] slot_next(input logic [PTR_W-1:0] s);
    return (s == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(s + 1'b1);
  endfunction

  function automatic logic [PTR_W-1:0] slot_prev(input logic [PTR_W-1:0] s);
    return (s == '0) ? PTR_W'(DEPTH - 1) : PTR_W'(s - 1'b1);
  endfunction

endpackage

// ----- sv/cd_ram.sv -----
// ---------------------------------------------------------------------------
// Circular deque RAM
// Generic memory with one write port and two registered read ports.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- sv/cd_ctrl.sv -----
// ---------------------------------------------------------------------------
// Circular deque controller
// Sequences each item through execute, fetch and response steps.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cd_ctrl
  import cd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  output logic    done,
  output cd_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FETCH,
    S_RESP
  } state_t;

  state_t state;

  always_comb begin
    cmd.load    = start && !busy;
    cmd.exec    = (state == S_EXEC);
    cmd.fetch   = (state == S_FETCH);
    cmd.capture = (state == S_RESP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_EXEC;
            busy  <= 1'b1;
          end
        end
        S_EXEC: begin
          state <= S_FETCH;
        end
        S_FETCH: begin
          state <= S_RESP;
        end
        S_RESP: begin
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ----- sv/cd_datapath.sv -----
// ---------------------------------------------------------------------------
// Circular deque datapath
// Slot pointers, entry count, entry store and the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cd_datapath
  import cd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  cd_cmd_t  cmd,
  input  request_t request,
  output result_t  result
);

  logic [2:0]               op_r;
  logic signed [DATA_W-1:0] val_r;
  logic [PTR_W-1:0]         front_slot;
  logic [PTR_W-1:0]         back_slot;
  logic [CNT_W-1:0]         stored_count;
  logic                     pop_ok;
  status_e                  status_r;
  logic signed [DATA_W-1:0] popped_r;

  logic             is_push;
  logic             is_pop;
  logic             full;
  logic             empty;
  logic [PTR_W-1:0] front_inc;
  logic [PTR_W-1:0] front_dec;
  logic [PTR_W-1:0] back_inc;
  logic [PTR_W-1:0] back_dec;
  logic             ram_we;
  logic [PTR_W-1:0] ram_waddr;
  logic [PTR_W-1:0] ram_raddr_a;
  logic [DATA_W-1:0] ram_rdata_a;
  logic [DATA_W-1:0] ram_rdata_b;

  always_comb begin
    is_push     = (op_r == OP_PUSH_FRONT) || (op_r == OP_PUSH_BACK);
    is_pop      = (op_r == OP_POP_FRONT) || (op_r == OP_POP_BACK);
    full        = (stored_count == CNT_W'(DEPTH));
    empty       = (stored_count == '0);
    front_inc   = slot_next(front_slot);
    front_dec   = slot_prev(front_slot);
    back_inc    = slot_next(back_slot);
    back_dec    = slot_prev(back_slot);
    ram_we      = cmd.exec && is_push && !full;
    ram_waddr   = (op_r == OP_PUSH_FRONT) ? front_slot : back_inc;
    ram_raddr_a = (cmd.fetch || (op_r == OP_POP_FRONT)) ? front_inc : back_slot;
  end

  cd_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (val_r),
    .raddr_a(ram_raddr_a),
    .rdata_a(ram_rdata_a),
    .raddr_b(back_slot),
    .rdata_b(ram_rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      front_slot   <= '0;
      back_slot    <= '0;
      stored_count <= '0;
      pop_ok       <= 1'b0;
    end else if (cmd.exec) begin
      pop_ok <= is_pop && !empty;
      if (is_push && !full) begin
        stored_count <= CNT_W'(stored_count + 1'b1);
        if (op_r == OP_PUSH_FRONT) begin
          front_slot <= front_dec;
        end else begin
          back_slot <= back_inc;
        end
      end else if (is_pop && !empty) begin
        stored_count <= CNT_W'(stored_count - 1'b1);
        if (op_r == OP_POP_FRONT) begin
          front_slot <= front_inc;
        end else begin
          back_slot <= back_dec;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= request.opcode;
      val_r <= request.push_value;
    end
    if (cmd.exec) begin
      if (is_push && full) begin
        status_r <= ST_FULL;
      end else if (is_pop && empty) begin
        status_r <= ST_EMPTY;
      end else begin
        status_r <= ST_OK;
      end
    end
    if (cmd.fetch) begin
      popped_r <= pop_ok ? ram_rdata_a : NONE_VALUE;
    end
    if (cmd.capture) begin
      result.popped_value <= popped_r;
      result.status       <= status_r;
      result.entry_count  <= stored_count;
      result.is_empty     <= empty;
      result.front_value  <= empty ? NONE_VALUE : ram_rdata_a;
      result.back_value   <= empty ? NONE_VALUE : ram_rdata_b;
    end
  end

endmodule

// ----- sv/circular_deque_top.sv -----
// done rises once the item has passed the execute, fetch and response states.
// No new item is accepted until the last one has gone through the execute, fetch and
// response steps around the single entry memory.
// The next item is accepted in the cycle in which done is high.
// Synchronous reset empties the deque; stored entries are not cleared.
// The receiver cannot stall: done is high for one cycle only for each result.
// ---------------------------------------------------------------------------
// Circular deque top level
// Double-ended queue of fixed depth kept in a circular entry memory.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "circular_deque_top_defines.svh"

module circular_deque_top
  import cd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  request_t request,
  output logic     done,
  output result_t  result
);

  cd_cmd_t cmd;

  cd_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .done (done),
    .cmd  (cmd)
  );

  cd_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .request(request),
    .result (result)
  );

  `CD_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done)
  `CD_ASSERT_SAME(a_done_idle, done, !busy)
  `CD_ASSERT_SAME(a_empty_flag, done, result.is_empty == (result.entry_count == '0))
  `CD_ASSERT_SAME(a_count_range, done, result.entry_count <= CNT_W'(DEPTH))

endmodule
